[design/gsc_pkg.sv]
// shared types and constants for the gray sensor calibration normalizer
// no dependencies
package gsc_pkg;
  localparam int Channels = 4;
  localparam int WindowDepth = 16;
  localparam int PtrW = $clog2(WindowDepth);
  localparam int SampleW = 12;
  localparam int SumW = SampleW + PtrW;
  localparam int NormW = 10;
  // divider numerator up to 4095*1000 < 2^22
  localparam int NumW = 22;
  localparam logic [SampleW-1:0] FullScale = 12'd4095;
  localparam logic [NormW-1:0] NormMid = 10'd500;
  localparam logic [NormW-1:0] NormScale = 10'd1000;
  localparam logic [15:0] DurationReset = 16'd5000;
  localparam logic [1:0] ModeFrame = 2'd0;
  localparam logic [1:0] ModeProc = 2'd1;
  localparam logic [1:0] ModeCal = 2'd2;
  localparam logic [1:0] ModeTick = 2'd3;
  localparam logic [0:0] AddrDuration = 1'b0;

  typedef struct packed {
    logic start;
    logic cal_complete;
    logic [SampleW-1:0] avg;
    logic [SampleW-1:0] hi;
    logic [SampleW-1:0] lo;
  } lane_req_t;
endpackage

[design/gsc_lane.sv]
// one channel lane: sequential restoring divider for the norm
// depends on gsc_pkg
module gsc_lane import gsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lane_req_t        req,
  output logic             busy,
  output logic [NormW-1:0] norm
);
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [SampleW:0] rem_r, rem_nxt;
  logic [SampleW-1:0] den_r;
  logic [4:0] cnt_r;
  logic busy_r, special_r;
  logic [NormW-1:0] fixed_r;
  logic [SampleW:0] trial;

  always_comb begin
    trial = {rem_r[SampleW-1:0], quo_r[NumW-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      quo_nxt = {quo_r[NumW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      den_r <= req.hi - req.lo;
      rem_r <= '0;
      quo_r <= NumW'((req.hi - req.avg) * 22'd1000);
      cnt_r <= 5'(NumW);
      if (!req.cal_complete || req.hi <= req.lo) begin
        special_r <= 1'b1; fixed_r <= NormMid; busy_r <= 1'b0;
      end else if (req.avg >= req.hi) begin
        special_r <= 1'b1; fixed_r <= '0; busy_r <= 1'b0;
      end else begin
        special_r <= 1'b0; busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign norm = special_r ? fixed_r :
                (quo_r > NumW'(NormScale)) ? NormScale : quo_r[NormW-1:0];
endmodule

[design/gray_sensor_calib_normalizer.sv]
// top level: frame ring, sums, calibration state, four divider lanes; needs gsc_pkg, gsc_lane
// frame, tick and start requests finish when accepted; a process request raises out_valid once
// the 22-step lane dividers are done (at once if all lanes have fixed norms)
// one process request at a time: in_ready stays low until its result is taken with out_ready
// reset: rst_n synchronous, active low, clears ring valid bits, sums, extremes, flags and
// tick count at once (no clearing pass)
module gray_sensor_calib_normalizer import gsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_mode,
  input  logic [SampleW-1:0] in_sample_ch0,
  input  logic [SampleW-1:0] in_sample_ch1,
  input  logic [SampleW-1:0] in_sample_ch2,
  input  logic [SampleW-1:0] in_sample_ch3,
  output logic out_valid,
  input  logic out_ready,
  output logic [NormW-1:0] out_norm_ch0,
  output logic [NormW-1:0] out_norm_ch1,
  output logic [NormW-1:0] out_norm_ch2,
  output logic [NormW-1:0] out_norm_ch3,
  output logic [3:0] out_line_bits,
  output logic [SampleW-1:0] out_avg_ch0,
  output logic [SampleW-1:0] out_avg_ch1,
  output logic [SampleW-1:0] out_avg_ch2,
  output logic [SampleW-1:0] out_avg_ch3,
  output logic out_calibrated,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  typedef enum logic [1:0] {S_IDLE, S_START, S_DIV, S_OUT} state_t;
  state_t state_r;

  // ring entries: valid bits stand in for the zero reset
  logic [SampleW-1:0] ring_r [WindowDepth][Channels];
  logic [WindowDepth-1:0] ring_vld_r;
  logic [PtrW-1:0] ptr_r;
  logic [SumW-1:0] sum_r [Channels];
  logic [SampleW-1:0] wmin_r [Channels];
  logic [SampleW-1:0] bmax_r [Channels];
  logic calibrating_r, done_r;
  logic [15:0] ticks_r, dur_r;
  logic [SampleW-1:0] avg_r [Channels];
  logic [SampleW-1:0] in_smp [Channels];
  lane_req_t req [Channels];
  logic [Channels-1:0] busy;
  logic [NormW-1:0] norm [Channels];
  logic [NormW-1:0] norm_r [Channels];
  logic cfg_wr;

  assign in_smp[0] = in_sample_ch0;
  assign in_smp[1] = in_sample_ch1;
  assign in_smp[2] = in_sample_ch2;
  assign in_smp[3] = in_sample_ch3;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[1] == AddrDuration) ? {16'd0, dur_r} : 32'd0;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  for (genvar c = 0; c < Channels; c++) begin : g_lane
    assign req[c].start = (state_r == S_START);
    assign req[c].cal_complete = done_r;
    assign req[c].avg = avg_r[c];
    assign req[c].hi = bmax_r[c];
    assign req[c].lo = wmin_r[c];
    gsc_lane u_lane (.clk(clk), .rst_n(rst_n), .req(req[c]),
                     .busy(busy[c]), .norm(norm[c]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ring_vld_r <= '0;
      ptr_r <= '0;
      calibrating_r <= 1'b0;
      done_r <= 1'b0;
      ticks_r <= '0;
      dur_r <= DurationReset;
      for (int c = 0; c < Channels; c++) begin
        sum_r[c] <= '0;
        wmin_r[c] <= FullScale;
        bmax_r[c] <= '0;
      end
    end else begin
      if (cfg_wr && cfg_paddr[1] == AddrDuration) dur_r <= cfg_pwdata[15:0];
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_mode)
              ModeFrame: begin
                for (int c = 0; c < Channels; c++) begin
                  sum_r[c] <= sum_r[c] + SumW'(in_smp[c])
                    - (ring_vld_r[ptr_r] ? SumW'(ring_r[ptr_r][c]) : SumW'(0));
                  ring_r[ptr_r][c] <= in_smp[c];
                end
                ring_vld_r[ptr_r] <= 1'b1;
                ptr_r <= ptr_r + 1'b1;
              end
              ModeProc: begin
                // average, then widen extremes while calibrating
                for (int c = 0; c < Channels; c++) begin
                  avg_r[c] <= sum_r[c][SumW-1:PtrW];
                  if (calibrating_r) begin
                    if (sum_r[c][SumW-1:PtrW] < wmin_r[c]) wmin_r[c] <= sum_r[c][SumW-1:PtrW];
                    if (sum_r[c][SumW-1:PtrW] > bmax_r[c]) bmax_r[c] <= sum_r[c][SumW-1:PtrW];
                  end
                end
                if (calibrating_r && ticks_r >= dur_r) begin
                  calibrating_r <= 1'b0;
                  done_r <= 1'b1;
                end
                state_r <= S_START;
              end
              ModeCal: begin
                calibrating_r <= 1'b1;
                done_r <= 1'b0;
                ticks_r <= '0;
                for (int c = 0; c < Channels; c++) begin
                  wmin_r[c] <= FullScale;
                  bmax_r[c] <= '0;
                end
              end
              ModeTick: if (ticks_r != 16'hFFFF) ticks_r <= ticks_r + 16'd1;
            endcase
          end
        end
        S_START: state_r <= S_DIV;
        S_DIV: if (busy == '0) begin
          for (int c = 0; c < Channels; c++) norm_r[c] <= norm[c];
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
      endcase
    end
  end

  // merge stage: lane results into the output request
  assign out_norm_ch0 = norm_r[0];
  assign out_norm_ch1 = norm_r[1];
  assign out_norm_ch2 = norm_r[2];
  assign out_norm_ch3 = norm_r[3];
  assign out_line_bits = {norm_r[3] > NormMid, norm_r[2] > NormMid,
                          norm_r[1] > NormMid, norm_r[0] > NormMid};
  assign out_avg_ch0 = avg_r[0];
  assign out_avg_ch1 = avg_r[1];
  assign out_avg_ch2 = avg_r[2];
  assign out_avg_ch3 = avg_r[3];
  assign out_calibrated = done_r;
endmodule

[test/gray_sensor_calib_normalizer_tb.sv]
// self-checking testbench for gray_sensor_calib_normalizer: directed table, then random phases
// depends on gsc_pkg and the design sources; in-line predictor, request/result scoreboard
module gray_sensor_calib_normalizer_tb;
  import gsc_pkg::*;

  localparam logic [1:0] DurAddr = 2'd0;
  localparam int Settle = 40;          // settling wait in drain after the last reading
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [3:0][NormW-1:0] norm;
    logic [3:0] lines;
    logic [3:0][SampleW-1:0] avg;
    logic cal;
  } reading_t;

  // one directed row; expected values are uniform across channels when typed in
  typedef struct {
    logic [1:0] mode;
    logic [3:0][SampleW-1:0] smp;
    int rep;
    bit typed;
    int unsigned norm;
    int unsigned avg;
    bit cal;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = ModeFrame;
  logic [3:0][SampleW-1:0] smp_drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NormW-1:0] norm0, norm1, norm2, norm3;
  logic [3:0] line_bits;
  logic [SampleW-1:0] avg0, avg1, avg2, avg3;
  logic calibrated;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = DurAddr;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #5 clk = ~clk;

  gray_sensor_calib_normalizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_sample_ch0(smp_drv[0]), .in_sample_ch1(smp_drv[1]),
    .in_sample_ch2(smp_drv[2]), .in_sample_ch3(smp_drv[3]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_norm_ch0(norm0), .out_norm_ch1(norm1), .out_norm_ch2(norm2), .out_norm_ch3(norm3),
    .out_line_bits(line_bits),
    .out_avg_ch0(avg0), .out_avg_ch1(avg1), .out_avg_ch2(avg2), .out_avg_ch3(avg3),
    .out_calibrated(calibrated),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // conditioner predictor state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  logic [3:0][SampleW-1:0] frames [WindowDepth];
  logic [PtrW-1:0] slot;
  logic [3:0][15:0] sums;
  logic [3:0][SampleW-1:0] white_min, black_max;
  bit cal_active, cal_done;
  logic [15:0] ticks, duration;

  reading_t pending_readings [$];
  int mismatches = 0;
  int readings_seen = 0;
  int requests_sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;   // no idling on either side

  task automatic clear_conditioner();
    foreach (frames[i]) frames[i] = '0;
    slot = '0;
    sums = '0;
    white_min = {4{FullScale}};
    black_max = '0;
    cal_active = 1'b0;
    cal_done = 1'b0;
    ticks = '0;
    duration = DurationReset;
  endtask

  // darkness of one channel: 1000 at the white end, 0 at the black end
  function automatic logic [NormW-1:0] darkness(int unsigned a, int unsigned hi,
                                                int unsigned lo, bit done);
    int unsigned n;
    if (!done || hi <= lo) return NormMid;
    if (a >= hi) return '0;
    n = (hi - a) * 1000 / (hi - lo);
    if (n > 1000) n = 1000;
    return NormW'(n);
  endfunction

  task automatic advance_conditioner(input logic [1:0] m, input logic [3:0][SampleW-1:0] s,
                                     output bit emits, output reading_t r);
    logic [SampleW-1:0] a;
    emits = 1'b0;
    r = '0;
    case (m)
      ModeFrame: begin
        for (int ch = 0; ch < 4; ch++) begin
          sums[ch] = sums[ch] - frames[slot][ch] + s[ch];
          frames[slot][ch] = s[ch];
        end
        slot = slot + 1'b1;
      end
      ModeProc: begin
        emits = 1'b1;
        for (int ch = 0; ch < 4; ch++) begin
          a = SampleW'(sums[ch] / WindowDepth);
          r.avg[ch] = a;
          if (cal_active) begin
            if (a < white_min[ch]) white_min[ch] = a;
            if (a > black_max[ch]) black_max[ch] = a;
          end
        end
        // end of calibration is decided after the extremes move
        if (cal_active && ticks >= duration) begin
          cal_active = 1'b0;
          cal_done = 1'b1;
        end
        for (int ch = 0; ch < 4; ch++) begin
          r.norm[ch] = darkness(r.avg[ch], black_max[ch], white_min[ch], cal_done);
          r.lines[ch] = r.norm[ch] > NormMid;
        end
        r.cal = cal_done;
      end
      ModeCal: begin
        cal_active = 1'b1;
        cal_done = 1'b0;
        white_min = {4{FullScale}};
        black_max = '0;
        ticks = '0;
      end
      default: begin
        if (ticks != 16'hFFFF) ticks = ticks + 1'b1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] m, input logic [3:0][SampleW-1:0] s,
                              input bit typed = 1'b0, input reading_t typed_r = '0);
    bit emits;
    reading_t r;
    in_valid <= 1'b1;
    in_mode <= m;
    smp_drv <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_conditioner(m, s, emits, r);
    requests_sent++;
    if (emits) pending_readings.push_back(typed ? typed_r : r);
    // random gap after the request
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // block idle: every reading in, and a frame/tick tail flushed
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_duration(input logic [15:0] d);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= DurAddr;
    cfg_pwdata <= {16'h0, d};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    duration = d;
    @(posedge clk);
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? FullScale : '0;
    return SampleW'($urandom_range(0, 4095));
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, checked against the oldest expectation
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.norm = {norm3, norm2, norm1, norm0};
      got.lines = line_bits;
      got.avg = {avg3, avg2, avg1, avg0};
      got.cal = calibrated;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading: %p", got);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading %0d mismatch: expected %p, got %p", readings_seen, want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL gray_sensor_calib_normalizer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  row_t script [$];

  function automatic void add(input logic [1:0] m, input logic [3:0][SampleW-1:0] s,
                              input int rep, input bit typed = 1'b0,
                              input int unsigned nv = 0, input int unsigned av = 0,
                              input bit cv = 1'b0);
    row_t r;
    r.mode = m; r.smp = s; r.rep = rep;
    r.typed = typed; r.norm = nv; r.avg = av; r.cal = cv;
    script.push_back(r);
  endfunction

  function automatic reading_t uniform(input row_t r);
    reading_t u;
    for (int ch = 0; ch < 4; ch++) begin
      u.norm[ch] = NormW'(r.norm);
      u.avg[ch] = SampleW'(r.avg);
      u.lines[ch] = r.norm > 500;
    end
    u.cal = r.cal;
    return u;
  endfunction

  initial begin
    logic [3:0][SampleW-1:0] s;
    logic [1:0] m;
    int pick;
    logic [15:0] phase_dur [4];

    clear_conditioner();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // duration of one tick keeps the directed calibrations short
    write_duration(16'd1);

    add(ModeProc, '0, 1, 1, 500, 0, 0);                 // fresh from reset
    add(ModeFrame, {4{FullScale}}, 16);
    add(ModeProc, '0, 1, 1, 500, 4095, 0);              // full-scale window
    add(ModeFrame, {12'h5A5, 12'hA5A, 12'hFFF, 12'h000}, 5);
    add(ModeProc, '0, 1);                               // partly refreshed window
    add(ModeFrame, '0, 16);
    add(ModeProc, '0, 1, 1, 500, 0, 0);
    add(ModeCal, '0, 1);
    add(ModeFrame, {4{FullScale}}, 16);
    add(ModeProc, '0, 1, 1, 500, 4095, 0);              // still calibrating
    add(ModeFrame, '0, 16);
    add(ModeProc, '0, 1, 1, 500, 0, 0);
    add(ModeTick, '0, 1);
    add(ModeProc, '0, 1, 1, 1000, 0, 1);                // ends calibration, white end
    add(ModeFrame, {4{FullScale}}, 16);
    add(ModeProc, '0, 1, 1, 0, 4095, 1);                // black end
    add(ModeFrame, {4{12'h800}}, 16);
    add(ModeProc, '0, 1);                               // mid range
    add(ModeCal, '0, 1);
    add(ModeProc, '0, 1, 1, 500, 2048, 0);              // restart drops completion
    add(ModeTick, '0, 3);

    foreach (script[i])
      for (int k = 0; k < script[i].rep; k++)
        send_request(script[i].mode, script[i].smp, script[i].typed, uniform(script[i]));
    drain();

    // random phases, each under its own duration
    phase_dur[0] = 16'($urandom_range(2, 40));
    phase_dur[1] = 16'd1;
    phase_dur[2] = DurationReset;
    phase_dur[3] = 16'($urandom_range(1, 12));
    for (int p = 0; p < 4; p++) begin
      write_duration(phase_dur[p]);
      quiet = (p == 3);
      for (int k = 0; k < 500; k++) begin
        pick = $urandom_range(0, 99);
        m = pick < 45 ? ModeFrame : pick < 70 ? ModeTick : pick < 95 ? ModeProc : ModeCal;
        for (int ch = 0; ch < 4; ch++) s[ch] = rand_sample();
        send_request(m, s);
        // sender holds off until every reading is back
        if (p == 1 && k == 250) drain();
      end
      drain();
    end

    $display("covered %0d requests and %0d readings over durations 1, 5000 and random",
             requests_sent, readings_seen);
    $display("with recalibration, partial windows and clamped norms; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("PASS gray_sensor_calib_normalizer");
    end else begin
      $display("FAIL gray_sensor_calib_normalizer");
    end
    $finish;
  end
endmodule

[files.f]
design/gsc_pkg.sv
design/gsc_lane.sv
design/gray_sensor_calib_normalizer.sv
test/gray_sensor_calib_normalizer_tb.sv
